/* hw/rtl/ordered_list_insert_delete_defines.svh */
// ----------------------------------------------------------------------------
// ordered list insert/delete assertion macros
// concurrent assertion helpers, empty when built for synthesis
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_DELETE_DEFINES_SVH
`define ORDERED_LIST_INSERT_DELETE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clk, quiet during reset
`define OLID_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("olid assertion failed");

// next-cycle implication, sampled on clk, quiet during reset
`define OLID_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("olid assertion failed");

`else

`define OLID_ASSERT_NOW(lbl, ante, cons)
`define OLID_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* hw/rtl/olid_pkg.sv */
// ----------------------------------------------------------------------------
// olid_pkg
// shared types and codes of the ordered list block
// ----------------------------------------------------------------------------
package olid_pkg;

	localparam int DATA_W  = 32;
	localparam int OP_W    = 2;
	localparam int MAX_CAP = 64;
	localparam int POS_W   = $clog2(MAX_CAP);

	// input opcodes
	localparam logic [OP_W-1:0] OP_FRONT = 2'd0;
	localparam logic [OP_W-1:0] OP_BACK  = 2'd1;
	localparam logic [OP_W-1:0] OP_DEL   = 2'd2;

	// classified command kinds
	localparam logic [1:0] CMD_NOP   = 2'd0;
	localparam logic [1:0] CMD_FRONT = 2'd1;
	localparam logic [1:0] CMD_BACK  = 2'd2;
	localparam logic [1:0] CMD_DEL   = 2'd3;

	typedef struct packed {
		logic [1:0]               kind;
		logic [POS_W-1:0]         pos;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic [POS_W:0] len;
	} back_stat_t;

endpackage

/* hw/rtl/olid_ifs.sv */
// ----------------------------------------------------------------------------
// olid channel interfaces
// valid/ready channels for commands and list results
// ----------------------------------------------------------------------------
interface olid_cmd_if;
	logic                               valid;
	logic                               ready;
	logic [olid_pkg::OP_W-1:0]          opcode;
	logic signed [olid_pkg::DATA_W-1:0] operand;

	modport source (output valid, output opcode, output operand, input ready);
	modport sink (input valid, input opcode, input operand, output ready);
endinterface

interface olid_res_if;
	logic                               valid;
	logic                               ready;
	logic signed [olid_pkg::DATA_W-1:0] element;
	logic                               list_empty;
	logic                               dropped;
	logic                               last;

	modport source (output valid, output element, output list_empty, output dropped,
		output last, input ready);
	modport sink (input valid, input element, input list_empty, input dropped,
		input last, output ready);
endinterface

/* hw/rtl/olid_ram.sv */
// ----------------------------------------------------------------------------
// olid_ram
// simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module olid_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// read data holds while re is low
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* hw/rtl/olid_front.sv */
// ----------------------------------------------------------------------------
// olid_front
// accepts commands, classifies them and registers the result
// ----------------------------------------------------------------------------
module olid_front #(
	parameter int CAPACITY = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	olid_cmd_if.sink         cmd,
	output logic             vld_s1,
	output olid_pkg::cmd_t   cmd_s1,
	input  logic             rdy
);

	olid_pkg::cmd_t cls;

	// negative or out-of-capacity positions never hit an element
	always_comb begin
		cls.value = cmd.operand;
		cls.pos   = cmd.operand[olid_pkg::POS_W-1:0];
		unique case (cmd.opcode)
			olid_pkg::OP_FRONT: cls.kind = olid_pkg::CMD_FRONT;
			olid_pkg::OP_BACK:  cls.kind = olid_pkg::CMD_BACK;
			olid_pkg::OP_DEL: begin
				if (!cmd.operand[31] && (cmd.operand[30:0] < 31'(CAPACITY))) begin
					cls.kind = olid_pkg::CMD_DEL;
				end else begin
					cls.kind = olid_pkg::CMD_NOP;
				end
			end
			default: cls.kind = olid_pkg::CMD_NOP;
		endcase
	end

	assign cmd.ready = !vld_s1 || rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.ready) begin
			vld_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1 <= cls;
		end
	end

endmodule

/* hw/rtl/olid_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// olid_cmd_fifo
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module olid_cmd_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  olid_pkg::cmd_t    push_cmd,
	input  logic              pop,
	output olid_pkg::cmd_t    pop_cmd,
	output olid_pkg::q_stat_t stat
);

	olid_pkg::cmd_t ent_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     cnt_q;
	logic           do_push;
	logic           do_pop;

	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_cmd    = ent_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

/* hw/rtl/olid_back.sv */
// ----------------------------------------------------------------------------
// olid_back
// applies commands to the ring store and streams the list out
// ----------------------------------------------------------------------------
module olid_back #(
	parameter int CAPACITY = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  olid_pkg::cmd_t       cmd_in,
	output logic                 cmd_pop,
	olid_res_if.source           result,
	output olid_pkg::back_stat_t stat
);

	localparam int AW    = $clog2(CAPACITY);
	localparam int DEPTH = 1 << AW;
	localparam int LW    = $clog2(CAPACITY + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SHIFT = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;

	logic [1:0]    state_q;
	logic [AW-1:0] head_q;
	logic [LW-1:0] len_q;
	logic          drop_q;
	logic [LW-1:0] idx_q;
	logic          sh_pend_q;
	logic [LW-1:0] sh_wr_q;
	logic          rd_pend_q;
	logic          rd_last_q;

	logic                               out_vld_q;
	logic signed [olid_pkg::DATA_W-1:0] out_elem_q;
	logic                               out_empty_q;
	logic                               out_drop_q;
	logic                               out_last_q;

	logic                        take;
	logic                        is_ins;
	logic                        full;
	logic                        ins_ok;
	logic                        del_hit;
	logic [LW-1:0]               pos_l;
	logic                        sh_rd;
	logic                        sh_wr_en;
	logic                        sh_done;
	logic                        out_free;
	logic                        load;
	logic                        em_rd;
	logic                        em_empty;

	logic                        ram_we;
	logic [AW-1:0]               ram_waddr;
	logic [olid_pkg::DATA_W-1:0] ram_wdata;
	logic                        ram_re;
	logic [AW-1:0]               ram_raddr;
	logic [olid_pkg::DATA_W-1:0] ram_rdata;

	olid_ram #(
		.WIDTH (olid_pkg::DATA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// command decode in idle
	assign take    = (state_q == ST_IDLE) && cmd_valid;
	assign is_ins  = (cmd_in.kind == olid_pkg::CMD_FRONT) || (cmd_in.kind == olid_pkg::CMD_BACK);
	assign full    = (len_q == LW'(CAPACITY));
	assign ins_ok  = take && is_ins && !full;
	assign pos_l   = LW'(cmd_in.pos);
	assign del_hit = take && (cmd_in.kind == olid_pkg::CMD_DEL) && (pos_l < len_q);
	assign cmd_pop = (state_q == ST_IDLE);

	// shift pass: read entry j, write it to j-1 the next cycle
	assign sh_rd    = (state_q == ST_SHIFT) && (idx_q < len_q);
	assign sh_wr_en = (state_q == ST_SHIFT) && sh_pend_q;
	assign sh_done  = (state_q == ST_SHIFT) && !sh_rd && !sh_pend_q;

	// emit pass: ram read data feeds the output register
	assign out_free = !out_vld_q || result.ready;
	assign load     = rd_pend_q && out_free;
	assign em_rd    = (state_q == ST_EMIT) && (len_q != '0) && (idx_q < len_q)
		&& (!rd_pend_q || load);
	assign em_empty = (state_q == ST_EMIT) && (len_q == '0) && out_free;

	always_comb begin
		ram_we    = ins_ok || sh_wr_en;
		ram_wdata = ram_rdata;
		ram_waddr = head_q + AW'(sh_wr_q);
		if (ins_ok) begin
			ram_wdata = cmd_in.value;
			if (cmd_in.kind == olid_pkg::CMD_FRONT) begin
				ram_waddr = head_q - AW'(1);
			end else begin
				ram_waddr = head_q + AW'(len_q);
			end
		end
		ram_re    = sh_rd || em_rd;
		ram_raddr = head_q + AW'(idx_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			head_q    <= '0;
			len_q     <= '0;
			drop_q    <= 1'b0;
			idx_q     <= '0;
			sh_pend_q <= 1'b0;
			sh_wr_q   <= '0;
			rd_pend_q <= 1'b0;
			rd_last_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take) begin
						drop_q    <= is_ins && full;
						sh_pend_q <= 1'b0;
						if (del_hit && (pos_l != '0)) begin
							idx_q   <= pos_l + LW'(1);
							state_q <= ST_SHIFT;
						end else begin
							idx_q   <= '0;
							state_q <= ST_EMIT;
						end
						if (ins_ok) begin
							len_q <= len_q + LW'(1);
							if (cmd_in.kind == olid_pkg::CMD_FRONT) begin
								head_q <= head_q - AW'(1);
							end
						end
						if (del_hit && (pos_l == '0)) begin
							head_q <= head_q + AW'(1);
							len_q  <= len_q - LW'(1);
						end
					end
				end
				ST_SHIFT: begin
					if (sh_rd) begin
						idx_q     <= idx_q + LW'(1);
						sh_pend_q <= 1'b1;
						sh_wr_q   <= idx_q - LW'(1);
					end else begin
						sh_pend_q <= 1'b0;
					end
					if (sh_done) begin
						len_q   <= len_q - LW'(1);
						idx_q   <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (em_rd) begin
						idx_q     <= idx_q + LW'(1);
						rd_pend_q <= 1'b1;
						rd_last_q <= (idx_q + LW'(1) == len_q);
					end else if (load) begin
						rd_pend_q <= 1'b0;
					end
					if ((load && rd_last_q) || em_empty) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (load || em_empty) begin
				out_vld_q <= 1'b1;
			end else if (result.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_elem_q  <= ram_rdata;
			out_empty_q <= 1'b0;
			out_drop_q  <= drop_q;
			out_last_q  <= rd_last_q;
		end else if (em_empty) begin
			out_elem_q  <= '0;
			out_empty_q <= 1'b1;
			out_drop_q  <= drop_q;
			out_last_q  <= 1'b1;
		end
	end

	assign result.valid      = out_vld_q;
	assign result.element    = out_elem_q;
	assign result.list_empty = out_empty_q;
	assign result.dropped    = out_drop_q;
	assign result.last       = out_last_q;

	assign stat.len = (olid_pkg::POS_W + 1)'(len_q);

endmodule

/* hw/rtl/ordered_list_insert_delete.sv */
// ----------------------------------------------------------------------------
// ordered_list_insert_delete
// bounded ordered list with front insert, back append and delete at position
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake      payload
//   -------  ---  -------------  -----------------------------------------
//   cmd      in   valid / ready  opcode[1:0], operand[31:0] signed
//   result   out  valid / ready  element[31:0] signed, list_empty, dropped,
//                                last
//
// each command is applied to the store, then the whole list is streamed out
// (the store has a single registered read port, one element a cycle while the
// result is not stalled); a delete behind the front first passes a shift state
// that moves every element behind the removed one down by one entry
// arst_n clears the list length and all handshake state; store contents are
// left as they are and only entries below the length are ever read
// a stalled result holds in the output register; a two-entry command queue
// lets the front keep taking transactions while the back is streaming
//
module ordered_list_insert_delete #(
	parameter int CAPACITY = 32
) (
	input logic        clk,
	input logic        arst_n,
	olid_cmd_if.sink   cmd,
	olid_res_if.source result
);

`include "ordered_list_insert_delete_defines.svh"

	// front stage output
	logic                 f_vld_s1;
	olid_pkg::cmd_t       f_cmd_s1;

	// queue side
	olid_pkg::q_stat_t    q_stat;
	olid_pkg::cmd_t       q_cmd;
	logic                 b_pop;

	olid_pkg::back_stat_t back_stat;

	// classify and register incoming transactions
	olid_front #(
		.CAPACITY (CAPACITY)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.vld_s1 (f_vld_s1),
		.cmd_s1 (f_cmd_s1),
		.rdy    (!q_stat.full)
	);

	// decouples front from the streaming back end
	olid_cmd_fifo u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (f_vld_s1),
		.push_cmd (f_cmd_s1),
		.pop      (b_pop),
		.pop_cmd  (q_cmd),
		.stat     (q_stat)
	);

	// applies the update and streams the list front to back
	olid_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!q_stat.empty),
		.cmd_in    (q_cmd),
		.cmd_pop   (b_pop),
		.result    (result),
		.stat      (back_stat)
	);

	// an empty-list result always closes its transaction group
	`OLID_ASSERT_NOW(a_empty_is_last, result.valid && result.list_empty, result.last)

	// a refused insert means the list was full, so never empty
	`OLID_ASSERT_NOW(a_drop_not_empty, result.valid && result.dropped, !result.list_empty)

	// list length never exceeds the capacity
	`OLID_ASSERT_NOW(a_len_bound, 1'b1, back_stat.len <= (olid_pkg::POS_W + 1)'(CAPACITY))

	// a full queue that is not popped is still occupied the next cycle
	`OLID_ASSERT_NEXT(a_queue_fill, q_stat.full && !b_pop, !q_stat.empty)

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// ordered list insert/delete testbench
// drives front inserts, back appends, deletes and no-op commands through the
// command channel under bursty traffic and a stalling result receiver; a
// scoreboard keeps its own copy of the list and checks every streamed element
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          CAPACITY   = 32;
	localparam int          CLK_PERIOD = 8;
	localparam int          RST_CYCLES = 5;
	localparam int          NUM_ITEMS  = 330;
	localparam int          DRAIN_CYC  = 100;
	localparam int unsigned CYCLE_CAP  = 400000;
	localparam int          HOLD_AFTER = 60;   // commands accepted before the long hold-off
	localparam int          HOLD_CYC   = 400;

	// opcode 3 is not a command; the list is left alone and streamed out again
	localparam logic [olid_pkg::OP_W-1:0] OP_NONE = 2'd3;

	// receiver stall patterns
	typedef enum logic [1:0] {
		RX_ALWAYS,
		RX_COIN,
		RX_SPARSE,
		RX_BURSTY
	} rx_mode_t;

	typedef struct packed {
		logic signed [olid_pkg::DATA_W-1:0] element;
		logic                               list_empty;
		logic                               dropped;
		logic                               last;
	} list_result_t;

	// ------------------------------------------------------------------------
	// scoreboard: private copy of the list plus the queue of awaited results
	// ------------------------------------------------------------------------
	class list_scoreboard;
		int unsigned                        capacity;
		logic signed [olid_pkg::DATA_W-1:0] list_copy[$];
		list_result_t                       awaited_results[$];
		int unsigned                        mismatches;

		function new(int unsigned cap);
			capacity   = cap;
			mismatches = 0;
		endfunction

		// apply one accepted command transaction and queue the list it streams out
		function void apply_command(logic [olid_pkg::OP_W-1:0] op,
			logic signed [olid_pkg::DATA_W-1:0] arg);
			logic         refused;
			list_result_t r;
			refused = 1'b0;
			case (op)
				olid_pkg::OP_FRONT, olid_pkg::OP_BACK: begin
					if (list_copy.size() >= capacity)
						refused = 1'b1;
					else if (op == olid_pkg::OP_FRONT)
						list_copy.push_front(arg);
					else
						list_copy.push_back(arg);
				end
				olid_pkg::OP_DEL: begin
					// a negative position or one at or past the end removes nothing
					if (!arg[olid_pkg::DATA_W-1] && $unsigned(arg) < list_copy.size())
						list_copy.delete(int'(arg));
				end
				default: ;
			endcase
			if (list_copy.size() == 0) begin
				r = '{element: '0, list_empty: 1'b1, dropped: refused, last: 1'b1};
				awaited_results.push_back(r);
			end else begin
				foreach (list_copy[i]) begin
					r.element    = list_copy[i];
					r.list_empty = 1'b0;
					r.dropped    = refused;
					r.last       = (i == list_copy.size() - 1);
					awaited_results.push_back(r);
				end
			end
		endfunction

		function void check_result(list_result_t got);
			list_result_t want;
			if (awaited_results.size() == 0) begin
				$display("%0t: unexpected result element %0d empty %0b dropped %0b last %0b",
					$time, got.element, got.list_empty, got.dropped, got.last);
				mismatches++;
				return;
			end
			want = awaited_results.pop_front();
			// element carries no meaning on an empty-list result
			if (!want.list_empty && got.element !== want.element) begin
				$display("%0t: element expected %0d got %0d", $time, want.element, got.element);
				mismatches++;
			end
			if (got.list_empty !== want.list_empty) begin
				$display("%0t: list_empty expected %0b got %0b", $time,
					want.list_empty, got.list_empty);
				mismatches++;
			end
			if (got.dropped !== want.dropped) begin
				$display("%0t: dropped expected %0b got %0b", $time, want.dropped, got.dropped);
				mismatches++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last expected %0b got %0b", $time, want.last, got.last);
				mismatches++;
			end
		endfunction

		function int unsigned outstanding();
			return awaited_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	olid_cmd_if cmd_ch ();
	olid_res_if res_ch ();

	ordered_list_insert_delete #(
		.CAPACITY(CAPACITY)
	) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd_ch),
		.result(res_ch)
	);

	list_scoreboard sb;
	int unsigned    commands_accepted;
	int unsigned    burst_left;
	int unsigned    cycle_count;

	// ------------------------------------------------------------------------
	// clock, reset and watchdog
	// ------------------------------------------------------------------------
	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	initial begin
		arst_n = 1'b0;
		repeat (RST_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_CAP) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// result monitor: every accepted result transaction goes to the scoreboard
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check_result('{element: res_ch.element, list_empty: res_ch.list_empty,
				dropped: res_ch.dropped, last: res_ch.last});
	end

	// ------------------------------------------------------------------------
	// result receiver: switches between stall patterns at random intervals,
	// and once holds ready low for a long stretch so the command queue fills
	// and the block has to push back on its input
	// ------------------------------------------------------------------------
	initial begin
		rx_mode_t    mode;
		int unsigned mode_left;
		int unsigned hold_left;
		int unsigned phase;
		bit          hold_done;
		res_ch.ready = 1'b0;
		mode         = RX_ALWAYS;
		mode_left    = 0;
		hold_left    = 0;
		phase        = 0;
		hold_done    = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && commands_accepted >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYC;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				phase++;
				case (mode)
					RX_ALWAYS: res_ch.ready <= 1'b1;
					RX_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
					RX_SPARSE: res_ch.ready <= ($urandom_range(0, 3) == 0);
					default:   res_ch.ready <= ((phase % 8) < 3);  // periodic on/off pattern, mostly off
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// command sender
	// ------------------------------------------------------------------------

	// offer one command transaction, opening a fresh burst after a random gap
	// when the current one is used up, and hold it until it is taken
	task automatic send_command(input logic [olid_pkg::OP_W-1:0] op,
		input logic signed [olid_pkg::DATA_W-1:0] arg);
		int unsigned gap;
		if (burst_left == 0) begin
			gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 20);
			repeat (gap) begin
				@(negedge clk);
				cmd_ch.valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		cmd_ch.valid   <= 1'b1;
		cmd_ch.opcode  <= op;
		cmd_ch.operand <= arg;
		forever begin
			@(posedge clk);
			if (cmd_ch.ready)
				break;
		end
		sb.apply_command(op, arg);
		commands_accepted++;
	endtask

	// insert value, leaning on the extremes now and then
	function automatic logic signed [olid_pkg::DATA_W-1:0] pick_value();
		case ($urandom_range(0, 15))
			0:       return 32'h7FFFFFFF;
			1:       return 32'h80000000;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	// delete position: mostly inside the list, sometimes at or past its end,
	// sometimes any 32-bit pattern including negative ones
	function automatic logic signed [olid_pkg::DATA_W-1:0] pick_position(int unsigned len);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (len > 0 && roll < 70)
			return $urandom_range(0, len - 1);
		else if (roll < 80)
			return len;
		else if (roll < 90)
			return $urandom_range(len, CAPACITY + 8);
		else
			return $urandom;
	endfunction

	// short directed run: empty list cases, extreme values, every opcode and
	// every kind of delete position
	task automatic run_directed();
		send_command(olid_pkg::OP_DEL, 0);               // delete on an empty list
		send_command(OP_NONE, $urandom);                 // no-op on an empty list
		send_command(olid_pkg::OP_FRONT, 32'h7FFFFFFF);
		send_command(olid_pkg::OP_BACK, 32'h80000000);
		send_command(olid_pkg::OP_FRONT, '1);
		send_command(olid_pkg::OP_BACK, '0);
		send_command(olid_pkg::OP_FRONT, 1);
		send_command(olid_pkg::OP_BACK, 32'h55555555);
		send_command(olid_pkg::OP_FRONT, 32'hAAAAAAAA);  // seven entries now
		send_command(olid_pkg::OP_DEL, 32'h80000000);    // most negative position
		send_command(olid_pkg::OP_DEL, '1);              // minus one
		send_command(olid_pkg::OP_DEL, 7);               // exactly the length
		send_command(olid_pkg::OP_DEL, 32'h7FFFFFFF);    // far past the end
		send_command(olid_pkg::OP_DEL, 3);               // from the middle
		send_command(olid_pkg::OP_DEL, 5);               // the last entry
		send_command(olid_pkg::OP_DEL, 0);               // the first entry
		send_command(OP_NONE, '1);                       // no-op on a populated list
		repeat (4) send_command(olid_pkg::OP_DEL, 0);    // drain back to empty
		send_command(olid_pkg::OP_DEL, 32'h12345678);
	endtask

	// random run in segments, each with its own lean toward growing or
	// shrinking; the first segment fills the list and keeps pushing past full
	task automatic run_random();
		int unsigned sent;
		int unsigned seg_left;
		int unsigned insert_pct;
		int unsigned roll;
		sent       = 0;
		seg_left   = CAPACITY + 8;
		insert_pct = 100;
		while (sent < NUM_ITEMS) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(30, 70);
				case ($urandom_range(0, 2))
					0:       insert_pct = 85;
					1:       insert_pct = 20;
					default: insert_pct = 50;
				endcase
			end
			seg_left--;
			roll = $urandom_range(0, 99);
			if (insert_pct < 100 && roll < 3)
				send_command(OP_NONE, $urandom);
			else if (roll < insert_pct)
				send_command($urandom_range(0, 1) ? olid_pkg::OP_FRONT : olid_pkg::OP_BACK,
					pick_value());
			else
				send_command(olid_pkg::OP_DEL, pick_position(sb.list_copy.size()));
			sent++;
		end
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		cmd_ch.valid      = 1'b0;
		cmd_ch.opcode     = olid_pkg::OP_FRONT;
		cmd_ch.operand    = '0;
		commands_accepted = 0;
		burst_left        = 0;
		sb                = new(CAPACITY);
		@(posedge arst_n);

		run_directed();
		run_random();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;

		// let the last list stream out, then watch for anything stray
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		if (sb.mismatches == 0 && sb.outstanding() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/olid_pkg.sv
hw/rtl/olid_ifs.sv
hw/rtl/olid_ram.sv
hw/rtl/olid_front.sv
hw/rtl/olid_cmd_fifo.sv
hw/rtl/olid_back.sv
hw/rtl/ordered_list_insert_delete.sv
dv/tb.sv
